FILE: rtl/bms_pkg.sv
// Package for the Brent minimizer sequencer: widths, codes, item types and helpers.
// Used by bms_mul, bms_div and brent_minimizer_sequencer; it depends on nothing else.
package bms_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int WW = 64;
  localparam int MAG_W = 62;
  localparam int MUL_STEPS = WW;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_W = MAG_W + FB;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [VW-1:0] value_t;

  localparam wide_t WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam wide_t VMAX = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t VMIN = -64'sh0000_0000_8000_0000;
  localparam wide_t GOLD = 64'sd25033;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_VALUE = 1'b1;

  localparam logic [1:0] KIND_PROBE  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] CFG_LEFT  = 2'd0;
  localparam logic [1:0] CFG_RIGHT = 2'd1;
  localparam logic [1:0] CFG_TOL   = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_PROBE = 2'd2;

  typedef struct packed {
    logic   req_type;
    value_t func_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    value_t      point;
    value_t      neg_min_value;
    logic [15:0] step_count;
  } out_item_t;

  typedef struct packed {
    logic  start;
    wide_t a;
    wide_t b;
  } op_req_t;

  typedef struct packed {
    logic  done;
    logic  busy;
    wide_t result;
  } op_rsp_t;

  function automatic wide_t widen(input value_t v);
    return {{(WW-VW){v[VW-1]}}, v};
  endfunction

  function automatic wide_t abs_w(input wide_t a);
    return a[WW-1] ? -a : a;
  endfunction

  function automatic wide_t sat_w(input wide_t a);
    wide_t r;
    if (a > WMAX) r = WMAX;
    else if (a < -WMAX) r = -WMAX;
    else r = a;
    return r;
  endfunction

  function automatic value_t sat_v(input wide_t a);
    wide_t r;
    if (a > VMAX) r = VMAX;
    else if (a < VMIN) r = VMIN;
    else r = a;
    return r[VW-1:0];
  endfunction

endpackage

FILE: rtl/bms_mul.sv
// Bit-serial fixed-point multiplier: one multiplier bit per cycle, saturating result.
// Depends on bms_pkg.
module bms_mul (
  input  logic             clk,
  input  logic             rst,
  input  bms_pkg::op_req_t req,
  output bms_pkg::op_rsp_t rsp
);

  logic [bms_pkg::WW-1:0]        ua;
  logic [bms_pkg::WW-1:0]        mb;
  logic [bms_pkg::WW-1:0]        hi;
  logic [bms_pkg::MUL_CNT_W-1:0] cnt;
  logic                          neg;
  logic                          busy;
  logic                          done;
  logic [bms_pkg::WW:0]          sum;
  bms_pkg::wide_t                mag;
  bms_pkg::wide_t                abs_a;
  bms_pkg::wide_t                abs_b;

  assign abs_a = bms_pkg::abs_w(req.a);
  assign abs_b = bms_pkg::abs_w(req.b);
  assign sum = {1'b0, hi} + (mb[0] ? {1'b0, ua} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ua <= abs_a;
        mb <= abs_b;
        hi <= '0;
        cnt <= '0;
        neg <= req.a[bms_pkg::WW-1] ^ req.b[bms_pkg::WW-1];
        busy <= 1'b1;
      end else if (busy) begin
        hi <= sum[bms_pkg::WW:1];
        mb <= {sum[0], mb[bms_pkg::WW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == bms_pkg::MUL_CNT_W'(bms_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (|hi[bms_pkg::WW-1:bms_pkg::MAG_W+bms_pkg::FB-bms_pkg::WW]) begin
      mag = bms_pkg::WMAX;
    end else begin
      mag = {2'b00, hi[bms_pkg::MAG_W+bms_pkg::FB-bms_pkg::WW-1:0],
             mb[bms_pkg::WW-1:bms_pkg::FB]};
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.result = neg ? -mag : mag;

endmodule

FILE: rtl/bms_div.sv
// Restoring fixed-point divider: one quotient bit per cycle, saturating result.
// Depends on bms_pkg.
module bms_div (
  input  logic             clk,
  input  logic             rst,
  input  bms_pkg::op_req_t req,
  output bms_pkg::op_rsp_t rsp
);

  logic [bms_pkg::WW-1:0]        rem;
  logic [bms_pkg::WW-1:0]        uq;
  logic [bms_pkg::DIV_W-1:0]     dvd;
  logic [bms_pkg::DIV_W-1:0]     quo;
  logic [bms_pkg::DIV_CNT_W-1:0] cnt;
  logic                          neg;
  logic                          zero;
  logic                          busy;
  logic                          done;
  logic [bms_pkg::WW-1:0]        r2;
  logic                          ge;
  bms_pkg::wide_t                abs_p;
  bms_pkg::wide_t                abs_q;
  bms_pkg::wide_t                mag;

  assign abs_p = bms_pkg::abs_w(req.a);
  assign abs_q = bms_pkg::abs_w(req.b);
  assign r2 = {rem[bms_pkg::WW-2:0], dvd[bms_pkg::DIV_W-1]};
  assign ge = r2 >= uq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        uq <= abs_q;
        dvd <= {abs_p[bms_pkg::MAG_W-1:0], {bms_pkg::FB{1'b0}}};
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        neg <= req.a[bms_pkg::WW-1] ^ req.b[bms_pkg::WW-1];
        zero <= (abs_q == '0);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? r2 - uq : r2;
        quo <= {quo[bms_pkg::DIV_W-2:0], ge};
        dvd <= {dvd[bms_pkg::DIV_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == bms_pkg::DIV_CNT_W'(bms_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) mag = '0;
    else if (|quo[bms_pkg::DIV_W-1:bms_pkg::MAG_W]) mag = bms_pkg::WMAX;
    else mag = {2'b00, quo[bms_pkg::MAG_W-1:0]};
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.result = neg ? -mag : mag;

endmodule

FILE: rtl/brent_minimizer_sequencer.sv
// Top level of the Brent minimizer sequencer: step sequencer and state registers.
// Depends on bms_pkg, bms_mul and bms_div.
//
// One request item is taken at a time and answered with exactly one response item. A start
// item and a golden-section step each wait on a product from the bit-serial multiplier, a
// value item that ends the search on neither unit, and a parabolic step on a chain of
// products, then on a quotient from the restoring divider or, if rejected, on a golden-section
// product; the sequencer uses the two units one after the other. A finished response waits
// in its own register, and the next request is taken while it waits.
module brent_minimizer_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bms_pkg::in_item_t   req_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bms_pkg::out_item_t  rsp_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SMUL   = 5'd1;
  localparam logic [4:0] S_TEST   = 5'd2;
  localparam logic [4:0] S_M1     = 5'd3;
  localparam logic [4:0] S_M2     = 5'd4;
  localparam logic [4:0] S_M3     = 5'd5;
  localparam logic [4:0] S_M4     = 5'd6;
  localparam logic [4:0] S_PQ     = 5'd7;
  localparam logic [4:0] S_M5     = 5'd8;
  localparam logic [4:0] S_M6     = 5'd9;
  localparam logic [4:0] S_M7     = 5'd10;
  localparam logic [4:0] S_GSTART = 5'd11;
  localparam logic [4:0] S_GOLD   = 5'd12;
  localparam logic [4:0] S_DIV    = 5'd13;
  localparam logic [4:0] S_CHK    = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_PUT    = 5'd16;

  logic [4:0]       state;
  logic [1:0]       phase;
  logic [15:0]      eval_count;
  bms_pkg::value_t  left_bound;
  bms_pkg::value_t  right_bound;
  logic [30:0]      abs_tolerance;
  bms_pkg::value_t  bracket_low;
  bms_pkg::value_t  bracket_high;
  bms_pkg::value_t  best_point;
  bms_pkg::value_t  second_point;
  bms_pkg::value_t  third_point;
  bms_pkg::value_t  best_value;
  bms_pkg::value_t  second_value;
  bms_pkg::value_t  third_value;
  bms_pkg::value_t  last_move;
  bms_pkg::value_t  prior_move;
  bms_pkg::value_t  probe_point;

  bms_pkg::wide_t   r_reg;
  bms_pkg::wide_t   q_reg;
  bms_pkg::wide_t   t_reg;
  bms_pkg::wide_t   s_reg;
  bms_pkg::wide_t   p_reg;
  bms_pkg::wide_t   e_reg;
  bms_pkg::wide_t   d_reg;
  logic             c1;
  logic             c2;
  logic             xlt_m;
  logic [1:0]       res_kind;
  bms_pkg::value_t  res_point;
  bms_pkg::value_t  res_neg;

  bms_pkg::op_req_t mul_req;
  bms_pkg::op_rsp_t mul_rsp;
  bms_pkg::op_req_t div_req;
  bms_pkg::op_rsp_t div_rsp;
  logic             mul_start;
  logic             div_start;
  logic             mul_go;
  logic             div_go;
  bms_pkg::wide_t   mul_a;
  bms_pkg::wide_t   mul_b;
  bms_pkg::wide_t   div_a;
  bms_pkg::wide_t   div_b;

  bms_pkg::wide_t   sa, sb, x, w, v, fx, fw, fv, tolw, t2;
  bms_pkg::wide_t   mid_sum, mid, half_w;
  logic             stop;
  logic             xlt;
  bms_pkg::wide_t   pd, qd, qn, p_new, q_new;
  bms_pkg::wide_t   uu;
  logic             near;
  bms_pkg::value_t  es, ds, us;
  bms_pkg::wide_t   dsw, uw;
  bms_pkg::value_t  f;
  bms_pkg::value_t  start_point;

  bms_mul u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  bms_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign f = req_item.func_value;
  assign mul_req = '{mul_start, mul_a, mul_b};
  assign div_req = '{div_start, div_a, div_b};

  always_comb begin
    sa = bms_pkg::widen(bracket_low);
    sb = bms_pkg::widen(bracket_high);
    x = bms_pkg::widen(best_point);
    w = bms_pkg::widen(second_point);
    v = bms_pkg::widen(third_point);
    fx = bms_pkg::widen(best_value);
    fw = bms_pkg::widen(second_value);
    fv = bms_pkg::widen(third_value);
    tolw = {33'b0, abs_tolerance};
    t2 = tolw + tolw;
    mid_sum = sa + sb;
    mid = mid_sum >>> 1;
    half_w = (sb - sa) >>> 1;
    stop = bms_pkg::abs_w(x - mid) <= (t2 - half_w);
    xlt = x < mid;
    pd = bms_pkg::sat_w(t_reg - s_reg);
    qd = bms_pkg::sat_w(q_reg - r_reg);
    qn = bms_pkg::sat_w(qd + qd);
    p_new = (qn > 0) ? -pd : pd;
    q_new = bms_pkg::abs_w(qn);
    uu = bms_pkg::sat_w(x + d_reg);
    near = (bms_pkg::sat_w(uu - sa) < t2) || (bms_pkg::sat_w(sb - uu) < t2);
    es = bms_pkg::sat_v(e_reg);
    ds = bms_pkg::sat_v(d_reg);
    dsw = bms_pkg::widen(ds);
    if (tolw <= bms_pkg::abs_w(dsw)) uw = x + dsw;
    else if (dsw > 0) uw = x + tolw;
    else uw = x - tolw;
    us = bms_pkg::sat_v(uw);
    start_point = bms_pkg::sat_v(bms_pkg::widen(left_bound) + mul_rsp.result);
  end

  always_comb begin
    mul_go = 1'b0;
    div_go = 1'b0;
    unique case (state)
      S_IDLE: mul_go = req_valid && (req_item.req_type == bms_pkg::REQ_START);
      S_TEST: mul_go = !stop && (tolw < bms_pkg::abs_w(bms_pkg::widen(last_move)));
      S_M1, S_M2, S_M3, S_M5, S_M6: mul_go = mul_rsp.done;
      S_PQ: mul_go = (q_new != '0);
      S_GSTART: mul_go = 1'b1;
      S_M7: div_go = mul_rsp.done && c1 && c2 && (p_reg < mul_rsp.result);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= mul_go;
      div_start <= div_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= bms_pkg::PH_IDLE;
      eval_count <= '0;
      rsp_valid <= 1'b0;
      left_bound <= '0;
      right_bound <= 32'sd6553600;
      abs_tolerance <= 31'd66;
      bracket_low <= '0;
      bracket_high <= '0;
      best_point <= '0;
      second_point <= '0;
      third_point <= '0;
      best_value <= '0;
      second_value <= '0;
      third_value <= '0;
      last_move <= '0;
      prior_move <= '0;
      probe_point <= '0;
    end else begin
      if (state == S_PUT && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_addr)
          bms_pkg::CFG_LEFT:  left_bound <= cfg_data;
          bms_pkg::CFG_RIGHT: right_bound <= cfg_data;
          bms_pkg::CFG_TOL:   abs_tolerance <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req_item.req_type == bms_pkg::REQ_START) begin
              bracket_low <= left_bound;
              bracket_high <= right_bound;
              eval_count <= '0;
              mul_a <= bms_pkg::GOLD;
              mul_b <= bms_pkg::widen(right_bound) - bms_pkg::widen(left_bound);
              state <= S_SMUL;
            end else if (phase != bms_pkg::PH_FIRST && phase != bms_pkg::PH_PROBE) begin
              res_kind <= bms_pkg::KIND_REJECT;
              res_point <= '0;
              res_neg <= '0;
              state <= S_PUT;
            end else begin
              if (eval_count != 16'hFFFF) eval_count <= eval_count + 1'b1;
              if (phase == bms_pkg::PH_FIRST) begin
                best_value <= f;
                second_value <= f;
                third_value <= f;
              end else if (f <= best_value) begin
                if (probe_point < best_point) bracket_high <= best_point;
                else bracket_low <= best_point;
                third_point <= second_point;
                third_value <= second_value;
                second_point <= best_point;
                second_value <= best_value;
                best_point <= probe_point;
                best_value <= f;
              end else begin
                if (probe_point < best_point) bracket_low <= probe_point;
                else bracket_high <= probe_point;
                if (f <= second_value || second_point == best_point) begin
                  third_point <= second_point;
                  third_value <= second_value;
                  second_point <= probe_point;
                  second_value <= f;
                end else if (f <= third_value || third_point == best_point ||
                             third_point == second_point) begin
                  third_point <= probe_point;
                  third_value <= f;
                end
              end
              state <= S_TEST;
            end
          end
        end
        S_SMUL: begin
          if (mul_rsp.done) begin
            best_point <= start_point;
            second_point <= start_point;
            third_point <= start_point;
            probe_point <= start_point;
            best_value <= '0;
            second_value <= '0;
            third_value <= '0;
            last_move <= '0;
            prior_move <= '0;
            phase <= bms_pkg::PH_FIRST;
            res_kind <= bms_pkg::KIND_PROBE;
            res_point <= start_point;
            res_neg <= '0;
            state <= S_PUT;
          end
        end
        S_TEST: begin
          xlt_m <= xlt;
          e_reg <= bms_pkg::widen(last_move);
          d_reg <= bms_pkg::widen(prior_move);
          if (stop) begin
            phase <= bms_pkg::PH_IDLE;
            res_kind <= bms_pkg::KIND_DONE;
            res_point <= best_point;
            res_neg <= bms_pkg::sat_v(-fx);
            state <= S_PUT;
          end else if (tolw < bms_pkg::abs_w(bms_pkg::widen(last_move))) begin
            mul_a <= x - w;
            mul_b <= fx - fv;
            state <= S_M1;
          end else begin
            state <= S_GSTART;
          end
        end
        S_M1: begin
          if (mul_rsp.done) begin
            r_reg <= mul_rsp.result;
            mul_a <= x - v;
            mul_b <= fx - fw;
            state <= S_M2;
          end
        end
        S_M2: begin
          if (mul_rsp.done) begin
            q_reg <= mul_rsp.result;
            mul_a <= x - v;
            mul_b <= mul_rsp.result;
            state <= S_M3;
          end
        end
        S_M3: begin
          if (mul_rsp.done) begin
            t_reg <= mul_rsp.result;
            mul_a <= x - w;
            mul_b <= r_reg;
            state <= S_M4;
          end
        end
        S_M4: begin
          if (mul_rsp.done) begin
            s_reg <= mul_rsp.result;
            state <= S_PQ;
          end
        end
        S_PQ: begin
          p_reg <= p_new;
          q_reg <= q_new;
          r_reg <= e_reg;
          e_reg <= d_reg;
          if (q_new == '0) begin
            state <= S_GSTART;
          end else begin
            mul_a <= q_new;
            mul_b <= e_reg;
            state <= S_M5;
          end
        end
        S_M5: begin
          if (mul_rsp.done) begin
            c1 <= bms_pkg::abs_w(p_reg) < (bms_pkg::abs_w(mul_rsp.result) >>> 1);
            mul_a <= q_reg;
            mul_b <= sa - x;
            state <= S_M6;
          end
        end
        S_M6: begin
          if (mul_rsp.done) begin
            c2 <= mul_rsp.result < p_reg;
            mul_a <= q_reg;
            mul_b <= sb - x;
            state <= S_M7;
          end
        end
        S_M7: begin
          if (mul_rsp.done) begin
            if (c1 && c2 && (p_reg < mul_rsp.result)) begin
              div_a <= p_reg;
              div_b <= q_reg;
              state <= S_DIV;
            end else begin
              state <= S_GSTART;
            end
          end
        end
        S_GSTART: begin
          e_reg <= xlt_m ? (sb - x) : (sa - x);
          mul_a <= bms_pkg::GOLD;
          mul_b <= xlt_m ? (sb - x) : (sa - x);
          state <= S_GOLD;
        end
        S_GOLD: begin
          if (mul_rsp.done) begin
            d_reg <= mul_rsp.result;
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            d_reg <= div_rsp.result;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (near) d_reg <= xlt_m ? tolw : -tolw;
          state <= S_FIN;
        end
        S_FIN: begin
          last_move <= es;
          prior_move <= ds;
          probe_point <= us;
          phase <= bms_pkg::PH_PROBE;
          res_kind <= bms_pkg::KIND_PROBE;
          res_point <= us;
          res_neg <= '0;
          state <= S_PUT;
        end
        S_PUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_item <= '{res_kind, res_point, res_neg, eval_count};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_neg_only_when_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.result_kind != bms_pkg::KIND_DONE) |-> rsp_item.neg_min_value == '0)
    else $error("nonzero negated minimum on a response that is not a completion");
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.result_kind != 2'd3)
    else $error("response kind out of range");
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy at the same time");
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("unused search phase reached");
`endif

endmodule
